// ===== rtl/bcgs_pkg.sv =====
// shared types and constants for the four-corner bilinear gradient sampler
// no dependencies; used by bcgs_div, bcgs_blend and the top level
package bcgs_pkg;

  localparam int COORD_W          = 16;
  localparam int WEIGHT_FRAC_BITS = 16;
  localparam int WGT_W            = WEIGHT_FRAC_BITS + 1;
  localparam int DIV_STEP         = 2;
  localparam int DIV_STAGES       = WEIGHT_FRAC_BITS / DIV_STEP;
  localparam int BLEND_STAGES     = 3;
  localparam int PIPE_DEPTH       = 1 + DIV_STAGES + BLEND_STAGES;
  localparam int CHAN_W           = 8;
  localparam int NUM_CHAN         = 4;
  localparam int COLOR_W          = CHAN_W * NUM_CHAN;
  localparam int EDGE_W           = CHAN_W + WEIGHT_FRAC_BITS;
  localparam int PROD_W           = CHAN_W + 2 * WEIGHT_FRAC_BITS;
  localparam int NUM_REGS         = 8;
  localparam int CFG_IDX_W        = $clog2(NUM_REGS);
  localparam int CFG_DATA_W       = COLOR_W;

  localparam logic [WGT_W-1:0] W_ONE = WGT_W'(1) << WEIGHT_FRAC_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RECT_LEFT          = 3'd0,
    REG_RECT_TOP           = 3'd1,
    REG_RECT_WIDTH         = 3'd2,
    REG_RECT_HEIGHT        = 3'd3,
    REG_COLOR_TOP_LEFT     = 3'd4,
    REG_COLOR_TOP_RIGHT    = 3'd5,
    REG_COLOR_BOTTOM_LEFT  = 3'd6,
    REG_COLOR_BOTTOM_RIGHT = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] sample_x;
    logic signed [COORD_W-1:0] sample_y;
  } sample_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
  } pixel_t;

  typedef struct packed {
    logic [COORD_W-1:0] rem;
    logic [COORD_W-1:0] span;
    logic               zero;
    logic               one;
  } div_in_t;

  typedef struct packed {
    logic [COLOR_W-1:0] tl;
    logic [COLOR_W-1:0] tr;
    logic [COLOR_W-1:0] bl;
    logic [COLOR_W-1:0] br;
  } corners_t;

endpackage

// ===== rtl/bilinear_corner_gradient_sampler.sv =====
// top level of the four-corner bilinear gradient sampler
// holds config registers, input skid, valid pipeline; uses bcgs_pkg, bcgs_div, bcgs_blend
//
// Takes one sample word per clock while the pipeline is not held, and returns one rgba
// pixel word per sample, in order, after an offset and edge-test stage, the two
// coordinate dividers (two quotient bits per stage), and the corner blend and rounding
// stages. The whole pipeline holds while an output word is stalled; a one-word skid
// register in front keeps in_stall a registered signal, so a sample offered during an
// output stall is still taken. Configuration writes take effect at once and are meant
// to happen while no samples are in flight.
module bilinear_corner_gradient_sampler (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  bcgs_pkg::sample_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output bcgs_pkg::pixel_t                  out_data,
  input  logic                              cfg_we,
  input  logic [bcgs_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [bcgs_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int CW = bcgs_pkg::COORD_W;

  logic [CW-1:0]                 rect_left_r;
  logic [CW-1:0]                 rect_top_r;
  logic [CW-1:0]                 rect_width_r;
  logic [CW-1:0]                 rect_height_r;
  bcgs_pkg::corners_t            corners_r;

  logic                          skid_vld_r;
  bcgs_pkg::sample_t             skid_r;
  logic [bcgs_pkg::PIPE_DEPTH-1:0] vld_r;

  bcgs_pkg::div_in_t             divx_r;
  bcgs_pkg::div_in_t             divy_r;
  bcgs_pkg::div_in_t             divx_nxt;
  bcgs_pkg::div_in_t             divy_nxt;

  logic                          en;
  logic                          src_valid;
  bcgs_pkg::sample_t             src;
  logic [CW:0]                   dx;
  logic [CW:0]                   dy;
  logic [bcgs_pkg::WGT_W-1:0]    u;
  logic [bcgs_pkg::WGT_W-1:0]    v;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rect_left_r   <= '0;
      rect_top_r    <= '0;
      rect_width_r  <= '0;
      rect_height_r <= '0;
      corners_r     <= '0;
    end else if (cfg_we) begin
      unique case (bcgs_pkg::cfg_reg_t'(cfg_idx))
        bcgs_pkg::REG_RECT_LEFT:          rect_left_r   <= cfg_data[CW-1:0];
        bcgs_pkg::REG_RECT_TOP:           rect_top_r    <= cfg_data[CW-1:0];
        bcgs_pkg::REG_RECT_WIDTH:         rect_width_r  <= cfg_data[CW-1:0];
        bcgs_pkg::REG_RECT_HEIGHT:        rect_height_r <= cfg_data[CW-1:0];
        bcgs_pkg::REG_COLOR_TOP_LEFT:     corners_r.tl  <= cfg_data;
        bcgs_pkg::REG_COLOR_TOP_RIGHT:    corners_r.tr  <= cfg_data;
        bcgs_pkg::REG_COLOR_BOTTOM_LEFT:  corners_r.bl  <= cfg_data;
        bcgs_pkg::REG_COLOR_BOTTOM_RIGHT: corners_r.br  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en        = !(out_valid && out_stall);
  assign in_stall  = skid_vld_r;
  assign src_valid = skid_vld_r || in_valid;
  assign src       = skid_vld_r ? skid_r : in_data;

  // offsets from the rectangle origin and saturation tests
  assign dx = {src.sample_x[CW-1], src.sample_x} - {rect_left_r[CW-1], rect_left_r};
  assign dy = {src.sample_y[CW-1], src.sample_y} - {rect_top_r[CW-1], rect_top_r};

  always_comb begin
    divx_nxt.rem  = dx[CW-1:0];
    divx_nxt.span = rect_width_r;
    divx_nxt.zero = (rect_width_r == '0) || dx[CW] || (dx == '0);
    divx_nxt.one  = !divx_nxt.zero && (dx[CW-1:0] >= rect_width_r);
    divy_nxt.rem  = dy[CW-1:0];
    divy_nxt.span = rect_height_r;
    divy_nxt.zero = (rect_height_r == '0) || dy[CW] || (dy == '0);
    divy_nxt.one  = !divy_nxt.zero && (dy[CW-1:0] >= rect_height_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_vld_r <= 1'b0;
      vld_r      <= '0;
    end else if (en) begin
      skid_vld_r <= 1'b0;
      vld_r      <= {vld_r[bcgs_pkg::PIPE_DEPTH-2:0], src_valid};
    end else if (in_valid && !skid_vld_r) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!en && in_valid && !skid_vld_r) begin
      skid_r <= in_data;
    end
    if (en) begin
      divx_r <= divx_nxt;
      divy_r <= divy_nxt;
    end
  end

  bcgs_div u_div_x (
    .clk (clk),
    .en  (en),
    .din (divx_r),
    .wgt (u)
  );

  bcgs_div u_div_y (
    .clk (clk),
    .en  (en),
    .din (divy_r),
    .wgt (v)
  );

  bcgs_blend u_blend (
    .clk     (clk),
    .en      (en),
    .u       (u),
    .v       (v),
    .corners (corners_r),
    .pixel   (out_data)
  );

  assign out_valid = vld_r[bcgs_pkg::PIPE_DEPTH-1];

`ifndef SYNTH
  a_skid_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_vld_r) |-> $past(out_valid && out_stall))
    else $error("skid filled while pipeline advanced");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_vld_r && en) |=> !skid_vld_r)
    else $error("skid word not drained on advance");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && en) |=> vld_r[0])
    else $error("accepted word lost at pipeline entry");
`endif

endmodule

// ===== rtl/bcgs_div.sv =====
// pipelined restoring divider for one normalized coordinate, DIV_STEP bits per stage
// gives offset / span with saturation to zero or one; uses bcgs_pkg
module bcgs_div (
  input  logic                         clk,
  input  logic                         en,
  input  bcgs_pkg::div_in_t            din,
  output logic [bcgs_pkg::WGT_W-1:0]   wgt
);

  logic [bcgs_pkg::COORD_W-1:0]          rem_in  [bcgs_pkg::DIV_STAGES];
  logic [bcgs_pkg::WEIGHT_FRAC_BITS-1:0] quo_in  [bcgs_pkg::DIV_STAGES];
  logic [bcgs_pkg::COORD_W-1:0]          span_in [bcgs_pkg::DIV_STAGES];
  logic                                  zero_in [bcgs_pkg::DIV_STAGES];
  logic                                  one_in  [bcgs_pkg::DIV_STAGES];

  logic [bcgs_pkg::COORD_W-1:0]          rem_r   [bcgs_pkg::DIV_STAGES];
  logic [bcgs_pkg::WEIGHT_FRAC_BITS-1:0] quo_r   [bcgs_pkg::DIV_STAGES];
  logic [bcgs_pkg::COORD_W-1:0]          span_r  [bcgs_pkg::DIV_STAGES];
  logic                                  zero_r  [bcgs_pkg::DIV_STAGES];
  logic                                  one_r   [bcgs_pkg::DIV_STAGES];

  for (genvar k = 0; k < bcgs_pkg::DIV_STAGES; k++) begin : g_stage
    logic [bcgs_pkg::COORD_W-1:0]          rem_nxt;
    logic [bcgs_pkg::WEIGHT_FRAC_BITS-1:0] quo_nxt;

    if (k == 0) begin : g_first
      assign rem_in[k]  = din.rem;
      assign quo_in[k]  = '0;
      assign span_in[k] = din.span;
      assign zero_in[k] = din.zero;
      assign one_in[k]  = din.one;
    end else begin : g_next
      assign rem_in[k]  = rem_r[k-1];
      assign quo_in[k]  = quo_r[k-1];
      assign span_in[k] = span_r[k-1];
      assign zero_in[k] = zero_r[k-1];
      assign one_in[k]  = one_r[k-1];
    end

    always_comb begin
      logic [bcgs_pkg::COORD_W+1:0] trial;
      rem_nxt = rem_in[k];
      quo_nxt = quo_in[k];
      for (int b = 0; b < bcgs_pkg::DIV_STEP; b++) begin
        trial = {1'b0, rem_nxt, 1'b0} - {2'b00, span_in[k]};
        if (!trial[bcgs_pkg::COORD_W+1]) begin
          rem_nxt = trial[bcgs_pkg::COORD_W-1:0];
          quo_nxt = {quo_nxt[bcgs_pkg::WEIGHT_FRAC_BITS-2:0], 1'b1};
        end else begin
          rem_nxt = {rem_nxt[bcgs_pkg::COORD_W-2:0], 1'b0};
          quo_nxt = {quo_nxt[bcgs_pkg::WEIGHT_FRAC_BITS-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        quo_r[k]  <= quo_nxt;
        span_r[k] <= span_in[k];
        zero_r[k] <= zero_in[k];
        one_r[k]  <= one_in[k];
      end
    end
  end

  always_comb begin
    if (one_r[bcgs_pkg::DIV_STAGES-1]) begin
      wgt = bcgs_pkg::W_ONE;
    end else if (zero_r[bcgs_pkg::DIV_STAGES-1]) begin
      wgt = '0;
    end else begin
      wgt = {1'b0, quo_r[bcgs_pkg::DIV_STAGES-1]};
    end
  end

endmodule

// ===== rtl/bcgs_blend.sv =====
// three-stage bilinear blend of four argb corners with round half up
// horizontal lerp, vertical products, then sum and round; uses bcgs_pkg
module bcgs_blend (
  input  logic                         clk,
  input  logic                         en,
  input  logic [bcgs_pkg::WGT_W-1:0]   u,
  input  logic [bcgs_pkg::WGT_W-1:0]   v,
  input  bcgs_pkg::corners_t           corners,
  output bcgs_pkg::pixel_t             pixel
);

  localparam int EW = bcgs_pkg::EDGE_W;
  localparam int PW = bcgs_pkg::PROD_W;
  localparam int CW = bcgs_pkg::CHAN_W;
  localparam int WW = bcgs_pkg::WGT_W;

  localparam logic [PW:0] HALF = (PW+1)'(1) << (2 * bcgs_pkg::WEIGHT_FRAC_BITS - 1);

  logic [WW-1:0]  v_r;
  logic [EW-1:0]  top_r [bcgs_pkg::NUM_CHAN];
  logic [EW-1:0]  bot_r [bcgs_pkg::NUM_CHAN];
  logic [PW-1:0]  ptop_r [bcgs_pkg::NUM_CHAN];
  logic [PW-1:0]  pbot_r [bcgs_pkg::NUM_CHAN];
  logic [CW-1:0]  chan_r [bcgs_pkg::NUM_CHAN];

  logic [WW-1:0]  nu;
  logic [WW-1:0]  nv;

  assign nu = bcgs_pkg::W_ONE - u;
  assign nv = bcgs_pkg::W_ONE - v_r;

  // byte 0 blue, 1 green, 2 red, 3 alpha
  for (genvar c = 0; c < bcgs_pkg::NUM_CHAN; c++) begin : g_chan
    logic [CW+WW-1:0] top_nxt;
    logic [CW+WW-1:0] bot_nxt;
    logic [EW+WW-1:0] ptop_nxt;
    logic [EW+WW-1:0] pbot_nxt;
    logic [PW:0]      sum_nxt;

    assign top_nxt  = corners.tl[CW*c +: CW] * nu + corners.tr[CW*c +: CW] * u;
    assign bot_nxt  = corners.bl[CW*c +: CW] * nu + corners.br[CW*c +: CW] * u;
    assign ptop_nxt = top_r[c] * nv;
    assign pbot_nxt = bot_r[c] * v_r;
    assign sum_nxt  = {1'b0, ptop_r[c]} + {1'b0, pbot_r[c]} + HALF;

    always_ff @(posedge clk) begin
      if (en) begin
        top_r[c]  <= top_nxt[EW-1:0];
        bot_r[c]  <= bot_nxt[EW-1:0];
        ptop_r[c] <= ptop_nxt[PW-1:0];
        pbot_r[c] <= pbot_nxt[PW-1:0];
        chan_r[c] <= sum_nxt[PW-1 -: CW];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r <= v;
    end
  end

  assign pixel.red   = chan_r[2];
  assign pixel.green = chan_r[1];
  assign pixel.blue  = chan_r[0];
  assign pixel.alpha = chan_r[3];

endmodule
